[hw/rtl/mpao_pkg.sv]
// Shared types, codes and constant tables for the phase-accumulator oscillator.
// Depends on nothing; used by the core and its port checker.
`timescale 1ns / 1ps
`default_nettype none

package mpao_pkg;

   localparam int PhaseBits  = 32;
   localparam int SampleBits = 16;
   localparam int TableDepth = 1024;
   localparam int TableAddrBits = 10;
   localparam int LenBits    = 11;
   localparam int SineDepth  = 256;
   localparam int SineIdxBits = 9;

   typedef enum logic [1:0] {
      FUNC_SAMPLE = 2'd0,
      FUNC_WRITE  = 2'd1,
      FUNC_PHASE  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      WAVE_SINE     = 3'd0,
      WAVE_TRIANGLE = 3'd1,
      WAVE_SAWTOOTH = 3'd2,
      WAVE_SQUARE   = 3'd3,
      WAVE_NOISE    = 3'd4,
      WAVE_TABLE    = 3'd5
   } wave_type;

   typedef enum logic [1:0] {
      CSR_WAVEFORM     = 2'd0,
      CSR_PHASE_STEP   = 2'd1,
      CSR_TABLE_LENGTH = 2'd2
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXP,
      ST_MUL,
      ST_SHIFT,
      ST_INTERP,
      ST_OUT
   } state_type;

   localparam logic [31:0] StepReset  = 32'd42852281;
   localparam logic [15:0] LfsrReset  = 16'hFFFF;
   localparam logic [15:0] LfsrTaps   = 16'hB400;

   typedef logic [17:0] exp_table_type [17];
   localparam exp_table_type Exp2Frac = '{
      18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
      18'd84990, 18'd88752, 18'd92682, 18'd96785, 18'd101070, 18'd105545,
      18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
   };

   typedef logic [15:0] sine_rom_type [SineDepth + 1];

   // Quarter-wave sine in Q15, built at elaboration from a Q30 Taylor series.
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] one;
      one = 64'd1 << 30;
      for (int k = 0; k <= SineDepth; k++) begin
         x  = (64'(k) * 64'd1686629713) / SineDepth;
         x2 = (x * x) >> 30;
         t  = one - x2 / 72;
         t  = one - ((x2 * t) >> 30) / 42;
         t  = one - ((x2 * t) >> 30) / 20;
         t  = one - ((x2 * t) >> 30) / 6;
         rom[k] = 16'((((x * t) >> 30) + 64'd16384) >> 15);
      end
      return rom;
   endfunction

   localparam sine_rom_type SineRom = build_sine_rom();

endpackage

`default_nettype wire

[hw/rtl/multiwave_phase_accumulator_oscillator_core.sv]
// Phase-accumulator oscillator core: FM step scaling, waveform generation,
// wavetable memory with interpolation. Depends on mpao_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// The request channel (req_*) carries one request per handshake: produce a
// sample, write one wavetable entry, or load the phase. Only a sample request
// yields a response on rsp_*, one signed Q1.15 sample.
// The csr_* port writes the waveform, phase step or table length, one per write;
// write it only while the core is idle.
// A write or phase-load request leaves the core idle. A sample request passes
// after acceptance through FM multiplier lookup, step multiply, octave shift
// plus first wavetable read, interpolation with the second read, and output.
// A sample request occupies the core until its return to idle; the two reads
// through the wavetable memory's single read port and the chained multiplies set this.
// The response sits in an output register; a new request is accepted while it
// waits, but the next sample holds in its output step until rsp_ready frees
// the register. After reset the phase is zero, the noise register all ones,
// configuration at its defaults, and the wavetable contents are undefined.

module multiwave_phase_accumulator_oscillator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic signed [15:0] req_fm_octaves,
   input  wire logic [9:0]  req_table_index,
   input  wire logic signed [15:0] req_table_value,
   input  wire logic [31:0] req_phase_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic signed [15:0] rsp_sample,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [31:0] csr_wdata
);

   mpao_pkg::state_type state_ff, state_in;

   logic [2:0]  waveform_ff;
   logic [31:0] step_ff;
   logic [10:0] length_ff;
   logic [31:0] phase_ff, phase_in;
   logic [15:0] lfsr_ff, lfsr_in;

   logic [11:0] frac_ff;
   logic [3:0]  shamt_ff;
   logic [17:0] mult_ff, mult_in;
   logic [42:0] tprod_ff;
   logic [49:0] val_ff;
   logic [31:0] inc_ff, inc_in;
   logic signed [15:0] a_ff;
   logic signed [15:0] wt_ff, wt_in;
   logic signed [15:0] sample_ff, sample_in;
   logic        rsp_valid_ff;

   logic [15:0] wt_mem [mpao_pkg::TableDepth];
   logic signed [15:0] rd_ff;
   logic [9:0]  rd_addr;

   logic        accept;
   logic        out_fire;
   logic [10:0] len;
   logic [10:0] i1, i2;
   logic [15:0] pos;

   assign accept   = req_valid && req_ready;
   assign out_fire = (state_ff == mpao_pkg::ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign len = (length_ff > 11'(mpao_pkg::TableDepth)) ? 11'(mpao_pkg::TableDepth)
                                                        : length_ff;
   assign pos = phase_ff[31:16];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mpao_pkg::ST_IDLE: begin
            if (accept && req_func == mpao_pkg::FUNC_SAMPLE) state_in = mpao_pkg::ST_EXP;
         end
         mpao_pkg::ST_EXP:    state_in = mpao_pkg::ST_MUL;
         mpao_pkg::ST_MUL:    state_in = mpao_pkg::ST_SHIFT;
         mpao_pkg::ST_SHIFT:  state_in = mpao_pkg::ST_INTERP;
         mpao_pkg::ST_INTERP: state_in = mpao_pkg::ST_OUT;
         mpao_pkg::ST_OUT: begin
            if (out_fire) state_in = mpao_pkg::ST_IDLE;
         end
         default: state_in = mpao_pkg::ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready = 1'b0;
      rd_addr   = i2[9:0];
      case (state_ff)
         mpao_pkg::ST_IDLE: req_ready = 1'b1;
         mpao_pkg::ST_MUL:  rd_addr   = i1[9:0];
         default: begin
            req_ready = 1'b0;
            rd_addr   = i2[9:0];
         end
      endcase
   end

   // Frequency multiplier 2^frac in Q16 by table and linear interpolation.
   always_comb begin
      logic [17:0] lo;
      logic [17:0] hi;
      logic [20:0] dl;
      lo = mpao_pkg::Exp2Frac[5'(frac_ff[11:8])];
      hi = mpao_pkg::Exp2Frac[5'(frac_ff[11:8]) + 5'd1];
      dl = 21'(hi - lo) * 21'(frac_ff[7:0]);
      mult_in = lo + 18'(dl >> 8);
   end

   // A right shift by seven minus the octave count, on a value padded by
   // seven bits, covers both directions.
   always_comb begin
      logic [64:0] wide;
      wide  = {8'd0, val_ff, 7'd0} >> shamt_ff;
      inc_in = wide[47:16];
   end

   // Wavetable entry addresses.
   always_comb begin
      i1 = tprod_ff[42:32];
      if (i1 >= len) i1 = len - 11'd1;
      i2 = (i1 + 11'd1 >= len) ? 11'd0 : i1 + 11'd1;
   end

   // Linear interpolation between the two entries.
   always_comb begin
      logic signed [16:0] diff;
      logic signed [33:0] step_part;
      logic signed [33:0] sum;
      diff = 17'(rd_ff) - 17'(a_ff);
      step_part = 34'(diff) * 34'($signed({1'b0, tprod_ff[31:16]}));
      sum  = (34'(a_ff) <<< 16) + step_part;
      wt_in = sum[31:16];
   end

   // Waveform selection, phase advance and noise step.
   always_comb begin
      logic [14:0] quad_pos;
      logic [8:0]  sidx;
      logic signed [16:0] q15;
      logic signed [17:0] d;
      logic [16:0] absd;
      quad_pos = pos[14] ? (15'd16384 - 15'(pos[13:0])) : 15'(pos[13:0]);
      sidx   = quad_pos[14:6];
      d      = $signed({2'b0, pos}) * 18'sd2 - 18'sd65536;
      absd   = d[17] ? 17'(-d) : 17'(d);
      lfsr_in = lfsr_ff;
      case (waveform_ff)
         mpao_pkg::WAVE_SINE: begin
            q15 = $signed({1'b0, mpao_pkg::SineRom[sidx]});
            if (pos[15]) q15 = -q15;
         end
         mpao_pkg::WAVE_TRIANGLE: q15 = 17'sd32768 - $signed(absd);
         mpao_pkg::WAVE_SAWTOOTH: q15 = 17'($signed(pos ^ 16'h8000));
         mpao_pkg::WAVE_SQUARE:   q15 = pos[15] ? -17'sd32768 : 17'sd32768;
         mpao_pkg::WAVE_NOISE: begin
            lfsr_in = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ mpao_pkg::LfsrTaps) : (lfsr_ff >> 1);
            q15 = 17'($signed(lfsr_in ^ 16'h8000));
         end
         mpao_pkg::WAVE_TABLE: begin
            if (len == 11'd0) begin
               q15 = $signed({1'b0, mpao_pkg::SineRom[sidx]});
               if (pos[15]) q15 = -q15;
            end else begin
               q15 = 17'(wt_ff);
            end
         end
         default: q15 = 17'sd0;
      endcase
      sample_in = (q15 > 17'sd32767) ? 16'sd32767 : q15[15:0];
      phase_in  = phase_ff + inc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpao_pkg::ST_IDLE;
         waveform_ff  <= mpao_pkg::WAVE_SINE;
         step_ff      <= mpao_pkg::StepReset;
         length_ff    <= '0;
         phase_ff     <= '0;
         lfsr_ff      <= mpao_pkg::LfsrReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_addr)
               mpao_pkg::CSR_WAVEFORM:     waveform_ff <= csr_wdata[2:0];
               mpao_pkg::CSR_PHASE_STEP:   step_ff     <= csr_wdata;
               mpao_pkg::CSR_TABLE_LENGTH: length_ff   <= csr_wdata[10:0];
               default: ;
            endcase
         end
         if (accept && req_func == mpao_pkg::FUNC_PHASE) begin
            phase_ff <= req_phase_value;
         end else if (out_fire) begin
            phase_ff <= phase_in;
         end
         if (out_fire) begin
            lfsr_ff      <= lfsr_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         frac_ff  <= req_fm_octaves[11:0];
         shamt_ff <= {req_fm_octaves[15], ~req_fm_octaves[14:12]};
      end
      if (state_ff == mpao_pkg::ST_EXP) begin
         mult_ff  <= mult_in;
         tprod_ff <= 43'(phase_ff) * 43'(len);
      end
      if (state_ff == mpao_pkg::ST_MUL) val_ff <= 50'(step_ff) * 50'(mult_ff);
      if (state_ff == mpao_pkg::ST_SHIFT) begin
         inc_ff <= inc_in;
         a_ff   <= rd_ff;
      end
      if (state_ff == mpao_pkg::ST_INTERP) wt_ff <= wt_in;
      if (out_fire) sample_ff <= sample_in;
   end

   // Wavetable memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (accept && req_func == mpao_pkg::FUNC_WRITE) begin
         wt_mem[req_table_index] <= req_table_value;
      end
      rd_ff <= $signed(wt_mem[rd_addr]);
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = sample_ff;

endmodule

`default_nettype wire

[hw/rtl/mpao_port_checker.sv]
// Port-level checks for the oscillator core, bound into every core instance.
// Depends on mpao_pkg and multiwave_phase_accumulator_oscillator_core.
`timescale 1ns / 1ps
`default_nettype none

module mpao_port_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_func,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_sample
);

   // A response that is not taken holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))
      else $error("held response changed");

   // Reset leaves no response pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A sample request keeps the core busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == mpao_pkg::FUNC_SAMPLE |=> !req_ready)
      else $error("sample request did not occupy the core");

   // A write or phase-load request never produces a response.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func != mpao_pkg::FUNC_SAMPLE |=> !$rose(rsp_valid))
      else $error("response raised by a request without a result");

endmodule

bind multiwave_phase_accumulator_oscillator_core mpao_port_checker u_mpao_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .req_func   (req_func),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_sample (rsp_sample)
);

`default_nettype wire
